[sv/dlip_pkg.sv]
// Shared types and constants for the display list index parser.
package dlip_pkg;

  // Parse phases: opcode, count bytes, then six vertex bytes
  localparam logic [3:0] PH_OPCODE = 4'd0;
  localparam logic [3:0] PH_CNT_HI = 4'd1;
  localparam logic [3:0] PH_CNT_LO = 4'd2;
  localparam logic [3:0] PH_VTX0   = 4'd3;
  localparam logic [3:0] PH_VTX1   = 4'd4;
  localparam logic [3:0] PH_VTX2   = 4'd5;
  localparam logic [3:0] PH_VTX3   = 4'd6;
  localparam logic [3:0] PH_VTX4   = 4'd7;
  localparam logic [3:0] PH_VTX5   = 4'd8;

  // Primitive type codes (opcode top five bits)
  localparam logic [7:0] PRIM_MASK  = 8'hF8;
  localparam logic [7:0] PRIM_QUADS = 8'h80;
  localparam logic [7:0] PRIM_TRIS  = 8'h90;
  localparam logic [7:0] PRIM_STRIP = 8'h98;
  localparam logic [7:0] PRIM_FAN   = 8'hA0;

  // Result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // End reasons
  localparam logic [1:0] REASON_CLEAN     = 2'd0;
  localparam logic [1:0] REASON_ZERO_OP   = 2'd1;
  localparam logic [1:0] REASON_BAD_PRIM  = 2'd2;
  localparam logic [1:0] REASON_TRUNCATED = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos;
    logic [15:0] nrm;
    logic [15:0] tex;
    logic [1:0]  reason;
    logic        last;
  } result_t;

endpackage

[sv/dlip_parser.sv]
// Byte parser: parse state and the up to two results produced by one byte.
module dlip_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        list_byte,
  input  logic              final_byte,
  output dlip_pkg::result_t res0,
  output dlip_pkg::result_t res1,
  output logic [1:0]        res_count
);
  import dlip_pkg::*;

  logic [3:0]  parse_phase, parse_phase_next;
  logic        halted, halted_next;
  logic [1:0]  stop_cause, stop_cause_next;
  logic [15:0] vertices_left, vertices_left_next;
  logic [39:0] gathered_bytes, gathered_bytes_next;

  logic        vtx_done;
  logic [15:0] vl_dec;
  logic [15:0] count_full;
  logic [7:0]  prim;
  logic        prim_ok;
  logic [1:0]  reason;
  result_t     vtx_res, end_res;

  assign prim    = list_byte & PRIM_MASK;
  assign prim_ok = (prim == PRIM_QUADS) || (prim == PRIM_TRIS) ||
                   (prim == PRIM_STRIP) || (prim == PRIM_FAN);
  assign vl_dec     = vertices_left - 16'd1;
  assign count_full = {gathered_bytes[7:0], list_byte};

  // Next state for one byte
  always_comb begin
    parse_phase_next    = parse_phase;
    halted_next         = halted;
    stop_cause_next     = stop_cause;
    vertices_left_next  = vertices_left;
    gathered_bytes_next = gathered_bytes;
    vtx_done            = 1'b0;
    if (!halted) begin
      unique case (parse_phase)
        PH_OPCODE: begin
          if (list_byte == 8'd0) begin
            halted_next     = 1'b1;
            stop_cause_next = REASON_ZERO_OP;
          end else if (!prim_ok) begin
            halted_next     = 1'b1;
            stop_cause_next = REASON_BAD_PRIM;
          end else begin
            parse_phase_next = PH_CNT_HI;
          end
        end
        PH_CNT_HI: begin
          gathered_bytes_next = {32'd0, list_byte};
          parse_phase_next    = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          vertices_left_next  = count_full;
          gathered_bytes_next = '0;
          parse_phase_next    = (count_full != 16'd0) ? PH_VTX0 : PH_OPCODE;
        end
        PH_VTX0, PH_VTX1, PH_VTX2, PH_VTX3, PH_VTX4: begin
          gathered_bytes_next = {gathered_bytes[31:0], list_byte};
          parse_phase_next    = parse_phase + 4'd1;
        end
        PH_VTX5: begin
          vtx_done            = 1'b1;
          gathered_bytes_next = '0;
          vertices_left_next  = vl_dec;
          parse_phase_next    = (vl_dec != 16'd0) ? PH_VTX0 : PH_OPCODE;
        end
        default: parse_phase_next = PH_OPCODE;
      endcase
    end

    // End of reason from the state this byte leaves
    if (halted_next) begin
      reason = stop_cause_next;
    end else if (parse_phase_next == PH_OPCODE) begin
      reason = REASON_CLEAN;
    end else begin
      reason = REASON_TRUNCATED;
    end

    // Final byte: list ends, state returns to its reset values
    if (final_byte) begin
      parse_phase_next    = PH_OPCODE;
      halted_next         = 1'b0;
      stop_cause_next     = REASON_CLEAN;
      vertices_left_next  = '0;
      gathered_bytes_next = '0;
    end
  end

  // Result words
  always_comb begin
    vtx_res.kind   = KIND_VERTEX;
    vtx_res.pos    = gathered_bytes[39:24];
    vtx_res.nrm    = gathered_bytes[23:8];
    vtx_res.tex    = {gathered_bytes[7:0], list_byte};
    vtx_res.reason = REASON_CLEAN;
    vtx_res.last   = !final_byte;
    end_res.kind   = KIND_END;
    end_res.pos    = '0;
    end_res.nrm    = '0;
    end_res.tex    = '0;
    end_res.reason = reason;
    end_res.last   = 1'b1;
    if (vtx_done) begin
      res0 = vtx_res;
    end else begin
      res0 = end_res;
    end
    res1      = end_res;
    res_count = {1'b0, vtx_done} + {1'b0, final_byte};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_OPCODE;
      halted         <= 1'b0;
      stop_cause     <= REASON_CLEAN;
      vertices_left  <= '0;
      gathered_bytes <= '0;
    end else if (take) begin
      parse_phase    <= parse_phase_next;
      halted         <= halted_next;
      stop_cause     <= stop_cause_next;
      vertices_left  <= vertices_left_next;
      gathered_bytes <= gathered_bytes_next;
    end
  end

endmodule

[sv/dlip_result_queue.sv]
// Four-entry result queue: takes up to two words a cycle, gives one unless stalled.
module dlip_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  dlip_pkg::result_t push0,
  input  dlip_pkg::result_t push1,
  input  logic [1:0]        push_count,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output dlip_pkg::result_t head
);
  import dlip_pkg::*;

  result_t     entries [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;
  logic        pop;
  logic [1:0]  wr_ptr1;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 3'd0);
  assign room      = (count < 3'd3);
  assign head      = entries[rd_ptr];
  assign wr_ptr1   = wr_ptr + 2'd1;
  assign count_next = count + {1'b0, push_count} - {2'b00, pop};

  // Storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr1] <= push1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

[sv/display_list_index_parser_core.sv]
// Display list index parser: one list byte a word in, vertex and end results out.
// A result is registered in the result queue when its byte is accepted and reaches the outputs behind earlier results.
// Throughput: one byte a cycle while the queue has room; the two results of one byte
// leave one at a time, and the four-entry result queue sets how far input runs ahead.
// Reset (synchronous) returns the parser to awaiting an opcode and empties the queue.
module display_list_index_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  list_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [15:0] position_index,
  output logic [15:0] normal_index,
  output logic [15:0] texcoord_index,
  output logic [1:0]  end_reason,
  output logic        last_of_run
);
  import dlip_pkg::*;

  logic       take;
  logic       room;
  logic [1:0] res_count;
  logic [1:0] push_count;
  result_t    res0, res1, head;

  assign in_stall   = !room;
  assign take       = in_valid && room;
  assign push_count = take ? res_count : 2'd0;

  dlip_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .list_byte  (list_byte),
    .final_byte (final_byte),
    .res0       (res0),
    .res1       (res1),
    .res_count  (res_count)
  );

  dlip_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (push_count),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  // Result fields
  assign result_kind    = head.kind;
  assign position_index = head.pos;
  assign normal_index   = head.nrm;
  assign texcoord_index = head.tex;
  assign end_reason     = head.reason;
  assign last_of_run    = head.last;

endmodule

[bench/tb_display_list_index_parser_core.sv]
// Testbench for display_list_index_parser_core: random and directed display lists.
`timescale 1ns / 1ps

module tb_display_list_index_parser_core;
  import dlip_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam int unsigned MAX_REPORTS = 20;

  // Receiver stall patterns
  localparam int unsigned STALL_NONE    = 0;
  localparam int unsigned STALL_LIGHT   = 1;
  localparam int unsigned STALL_HEAVY   = 2;
  localparam int unsigned STALL_PATTERN = 3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  list_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [15:0] position_index;
  logic [15:0] normal_index;
  logic [15:0] texcoord_index;
  logic [1:0]  end_reason;
  logic        last_of_run;

  // Parser state mirrored by the predictor
  logic [3:0]  ph        = PH_OPCODE;
  logic        stopped   = 1'b0;
  logic [1:0]  stop_why  = REASON_CLEAN;
  logic [15:0] verts_due = '0;
  logic [39:0] gathered  = '0;

  result_t     pending_words[$];
  logic [7:0]  list_q[$];

  int unsigned errors       = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b0;
  int unsigned stall_mode   = STALL_NONE;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned lists_sent   = 0;
  int unsigned vertex_words = 0;
  int unsigned end_words    = 0;
  int unsigned reason_seen[4];

  display_list_index_parser_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .list_byte      (list_byte),
    .final_byte     (final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .position_index (position_index),
    .normal_index   (normal_index),
    .texcoord_index (texcoord_index),
    .end_reason     (end_reason),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_prim(input logic [7:0] op);
    logic [7:0] t;
    t = op & PRIM_MASK;
    return t == PRIM_QUADS || t == PRIM_TRIS || t == PRIM_STRIP || t == PRIM_FAN;
  endfunction

  // Advance the mirrored parser by one byte and queue the words it should emit
  task automatic predict_indices(input logic [7:0] b, input logic fin);
    result_t w;
    if (!stopped) begin
      case (ph)
        PH_OPCODE: begin
          if (b == 8'h00) begin
            stopped  = 1'b1;
            stop_why = REASON_ZERO_OP;
          end else if (!is_prim(b)) begin
            stopped  = 1'b1;
            stop_why = REASON_BAD_PRIM;
          end else begin
            ph = PH_CNT_HI;
          end
        end
        PH_CNT_HI: begin
          gathered = {32'd0, b};
          ph = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          verts_due = {gathered[7:0], b};
          gathered  = '0;
          ph = (verts_due != 0) ? PH_VTX0 : PH_OPCODE;
        end
        PH_VTX0, PH_VTX1, PH_VTX2, PH_VTX3, PH_VTX4: begin
          gathered = {gathered[31:0], b};
          ph = ph + 4'd1;
        end
        PH_VTX5: begin
          w.kind   = KIND_VERTEX;
          w.pos    = gathered[39:24];
          w.nrm    = gathered[23:8];
          w.tex    = {gathered[7:0], b};
          w.reason = REASON_CLEAN;
          w.last   = !fin;
          pending_words.push_back(w);
          gathered  = '0;
          verts_due = verts_due - 16'd1;
          ph = (verts_due != 0) ? PH_VTX0 : PH_OPCODE;
        end
        default: ph = PH_OPCODE;
      endcase
    end
    // End word, then back to the reset state for the next list
    if (fin) begin
      w.kind = KIND_END;
      w.pos  = '0;
      w.nrm  = '0;
      w.tex  = '0;
      if (stopped)
        w.reason = stop_why;
      else if (ph == PH_OPCODE)
        w.reason = REASON_CLEAN;
      else
        w.reason = REASON_TRUNCATED;
      w.last = 1'b1;
      pending_words.push_back(w);
      ph        = PH_OPCODE;
      stopped   = 1'b0;
      stop_why  = REASON_CLEAN;
      verts_due = '0;
      gathered  = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Offer one word; bursts with random gaps when gaps are enabled
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    list_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    predict_indices(b, fin);
    bytes_sent++;
  endtask

  // Send list_q with the final flag on its last byte
  task automatic send_list();
    foreach (list_q[i])
      send_byte(list_q[i], i == list_q.size() - 1);
    lists_sent++;
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  function automatic logic [7:0] random_prim();
    logic [7:0] t;
    case ($urandom_range(0, 3))
      0: t = PRIM_QUADS;
      1: t = PRIM_TRIS;
      2: t = PRIM_STRIP;
      default: t = PRIM_FAN;
    endcase
    return t | 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] bad_opcode();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_prim(b));
    return b;
  endfunction

  // Build one list: mostly well-formed commands, some stops, cuts and noise
  task automatic gen_list();
    int unsigned style;
    int unsigned nvtx;
    int unsigned keep;
    logic [15:0] cnt;
    bit          cut_short;
    list_q.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) list_q.push_back(8'($urandom));
    end else begin
      cut_short = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        if (!cut_short) begin
          list_q.push_back(random_prim());
          cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
          list_q.push_back(cnt[15:8]);
          list_q.push_back(cnt[7:0]);
          // large counts: a few vertices, then the list runs out
          nvtx = (cnt > 4) ? $urandom_range(0, 4) : cnt;
          cut_short = cnt > 4;
          repeat (nvtx * 6) list_q.push_back(8'($urandom));
        end
      end
      case (style)
        1: begin
          list_q.push_back(8'h00);
          repeat ($urandom_range(0, 3)) list_q.push_back(8'($urandom));
        end
        2: begin
          list_q.push_back(bad_opcode());
          repeat ($urandom_range(0, 3)) list_q.push_back(8'($urandom));
        end
        3: begin
          keep = $urandom_range(1, list_q.size());
          while (list_q.size() > keep) void'(list_q.pop_back());
        end
        default: ;
      endcase
    end
  endtask

  // Receiver: long hold-off on request, otherwise the current stall pattern
  initial begin : receiver
    int unsigned tick;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
          STALL_PATTERN: out_stall <= ((tick % 5) < 2);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d reason %0d", result_kind,
                                  end_reason));
      end else begin
        want = pending_words.pop_front();
        if (result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, want.kind));
        if (position_index !== want.pos)
          report_mismatch($sformatf("position_index 0x%04h, expected 0x%04h",
                                    position_index, want.pos));
        if (normal_index !== want.nrm)
          report_mismatch($sformatf("normal_index 0x%04h, expected 0x%04h",
                                    normal_index, want.nrm));
        if (texcoord_index !== want.tex)
          report_mismatch($sformatf("texcoord_index 0x%04h, expected 0x%04h",
                                    texcoord_index, want.tex));
        if (end_reason !== want.reason)
          report_mismatch($sformatf("end_reason %0d, expected %0d", end_reason, want.reason));
        if (last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0d, expected %0d", last_of_run, want.last));
        if (want.kind == KIND_END) begin
          end_words++;
          reason_seen[want.reason]++;
        end else begin
          vertex_words++;
        end
      end
    end
  end

  // Watchdog: no word accepted on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Hand-picked lists: each end reason, every primitive, index extremes
  task automatic test_directed();
    gaps_on    = 1'b1;
    stall_mode = STALL_LIGHT;
    // one-byte list ending on a zero opcode
    list_q = '{8'h00};
    send_list();
    // unsupported primitive, trailing byte ignored
    list_q = '{8'hFF, 8'h12};
    send_list();
    // zero vertex count, then a fan opcode cut off before its count
    list_q = '{8'h98, 8'h00, 8'h00, 8'hA0};
    send_list();
    // final byte completes a vertex: vertex word plus clean end
    list_q = '{8'h87, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_list();
    // partial second vertex is dropped, end reports truncation
    list_q = '{8'h90, 8'h00, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12,
               8'h34};
    send_list();
    wait_drained();
  endtask

  // Many random lists, idling style picked per list
  task automatic test_random_lists();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
      end else begin
        gaps_on    = $urandom_range(0, 3) != 0;
        stall_mode = $urandom_range(STALL_NONE, STALL_PATTERN);
      end
      gen_list();
      send_list();
      if ($urandom_range(0, 39) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  // Receiver holds off while a long list keeps coming, so the input stalls
  task automatic test_backpressure();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_req   = 1'b1;
    list_q.delete();
    list_q.push_back(PRIM_TRIS);
    list_q.push_back(8'h00);
    list_q.push_back(8'h08);
    repeat (8 * 6) list_q.push_back(8'($urandom));
    send_list();
    wait_drained();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    list_byte  = 8'h00;
    final_byte = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_lists();
    test_backpressure();

    stall_mode = STALL_NONE;
    repeat (8) @(posedge clk);
    $display("Sent %0d list bytes in %0d lists; checked %0d vertex and %0d end words",
             bytes_sent, lists_sent, vertex_words, end_words);
    $display("End reasons seen: clean %0d, zero opcode %0d, bad primitive %0d, truncated %0d",
             reason_seen[REASON_CLEAN], reason_seen[REASON_ZERO_OP],
             reason_seen[REASON_BAD_PRIM], reason_seen[REASON_TRUNCATED]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
sv/dlip_pkg.sv
sv/dlip_parser.sv
sv/dlip_result_queue.sv
sv/display_list_index_parser_core.sv
bench/tb_display_list_index_parser_core.sv
